[design/elt_pkg.sv]
// Package for the expression line tokenizer: token kinds, lexer modes,
// character codes and the character classification helpers.
// No dependencies.
package elt_pkg;

    typedef enum logic [4:0] {
        K_WORD     = 5'd0,
        K_INT      = 5'd1,
        K_LPAREN   = 5'd2,
        K_RPAREN   = 5'd3,
        K_POW      = 5'd4,
        K_PLUS     = 5'd5,
        K_MINUS    = 5'd6,
        K_STAR     = 5'd7,
        K_SLASH    = 5'd8,
        K_LT       = 5'd9,
        K_LE       = 5'd10,
        K_GT       = 5'd11,
        K_GE       = 5'd12,
        K_ASSIGN   = 5'd13,
        K_EQ       = 5'd14,
        K_NE       = 5'd15,
        K_LBRACKET = 5'd16,
        K_RBRACKET = 5'd17,
        K_SEMI     = 5'd18,
        K_EOL      = 5'd19,
        K_ERR      = 5'd20
    } kind_t;

    typedef enum logic [7:0] {
        M_IDLE = 8'b0000_0001,
        M_WORD = 8'b0000_0010,
        M_INT  = 8'b0000_0100,
        M_LT   = 8'b0000_1000,
        M_GT   = 8'b0001_0000,
        M_EQ   = 8'b0010_0000,
        M_BANG = 8'b0100_0000,
        M_SKIP = 8'b1000_0000
    } mode_t;

    localparam logic [7:0] C_NUL    = 8'h00;
    localparam logic [7:0] C_LF     = 8'h0A;
    localparam logic [7:0] C_CR     = 8'h0D;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_LPAREN = 8'h28;
    localparam logic [7:0] C_RPAREN = 8'h29;
    localparam logic [7:0] C_POW    = 8'h5E;
    localparam logic [7:0] C_PLUS   = 8'h2B;
    localparam logic [7:0] C_MINUS  = 8'h2D;
    localparam logic [7:0] C_STAR   = 8'h2A;
    localparam logic [7:0] C_SLASH  = 8'h2F;
    localparam logic [7:0] C_LBRACK = 8'h5B;
    localparam logic [7:0] C_RBRACK = 8'h5D;
    localparam logic [7:0] C_SEMI   = 8'h3B;
    localparam logic [7:0] C_LT     = 8'h3C;
    localparam logic [7:0] C_GT     = 8'h3E;
    localparam logic [7:0] C_EQ     = 8'h3D;
    localparam logic [7:0] C_BANG   = 8'h21;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] text;
        logic       start;
        logic       last;
    } res_t;

    typedef struct packed {
        logic  valid;
        res_t  res;
        mode_t mode;
    } idle_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic res_t mk(input kind_t k, input logic [7:0] t, input logic s);
        res_t r;
        r.kind  = k;
        r.text  = t;
        r.start = s;
        r.last  = 1'b0;
        return r;
    endfunction

    // character seen with nothing pending
    function automatic idle_t idle_char(input logic [7:0] c);
        idle_t o;
        o.valid = 1'b1;
        o.mode  = M_IDLE;
        o.res   = mk(K_ERR, c, 1'b1);
        if (c == C_SPACE) begin
            o.valid = 1'b0;
        end else if (is_letter(c)) begin
            o.mode = M_WORD;
            o.res  = mk(K_WORD, c, 1'b1);
        end else if (is_digit(c)) begin
            o.mode = M_INT;
            o.res  = mk(K_INT, c, 1'b1);
        end else begin
            case (c)
                C_LPAREN: o.res = mk(K_LPAREN, 8'h00, 1'b1);
                C_RPAREN: o.res = mk(K_RPAREN, 8'h00, 1'b1);
                C_POW:    o.res = mk(K_POW, 8'h00, 1'b1);
                C_PLUS:   o.res = mk(K_PLUS, 8'h00, 1'b1);
                C_MINUS:  o.res = mk(K_MINUS, 8'h00, 1'b1);
                C_STAR:   o.res = mk(K_STAR, 8'h00, 1'b1);
                C_SLASH:  o.res = mk(K_SLASH, 8'h00, 1'b1);
                C_LBRACK: o.res = mk(K_LBRACKET, 8'h00, 1'b1);
                C_RBRACK: o.res = mk(K_RBRACKET, 8'h00, 1'b1);
                C_SEMI:   o.res = mk(K_SEMI, 8'h00, 1'b1);
                C_LT:
                begin
                    o.valid = 1'b0;
                    o.mode  = M_LT;
                end
                C_GT:
                begin
                    o.valid = 1'b0;
                    o.mode  = M_GT;
                end
                C_EQ:
                begin
                    o.valid = 1'b0;
                    o.mode  = M_EQ;
                end
                C_BANG:
                begin
                    o.valid = 1'b0;
                    o.mode  = M_BANG;
                end
                default:  o.mode = M_SKIP;
            endcase
        end
        return o;
    endfunction

endpackage

[design/expression_line_tokenizer_core.sv]
// Top level of the expression line tokenizer: lexer state machine and a
// four-entry result queue. Depends on elt_pkg.
//
// One character is taken per cycle while s_tready is high and yields zero,
// one or two tokens, which leave one per cycle from a four-entry queue while
// m_tready is high. s_tready stays high while the queue has room for two
// entries, so with m_tready high the sustained rate is one character per
// cycle when each character gives at most one token; one that gives two (a
// held < > = before a character that starts a token, or a held < > = ! at
// line end) fills two queue entries. The mode register holds the lexer state.
module expression_line_tokenizer_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // ch[7:0]
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // text_char[7:0]
    output logic [5:0] m_tuser,   // kind[4:0], token_start[5]
    output logic       m_tlast    // last
);
    import elt_pkg::*;

    mode_t      mode_reg, mode_next;
    res_t       r0, r1;
    logic       v0, v1;
    idle_t      ic;
    res_t       held;
    logic       is_held;
    logic       eol;

    res_t       q_reg [4];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] cnt_reg, cnt_next;
    logic       push, pop;
    logic [1:0] wr1;
    logic [2:0] push_n;

    assign eol     = (s_tdata == C_LF) || (s_tdata == C_CR) || (s_tdata == C_NUL);
    assign ic      = idle_char(s_tdata);
    assign is_held = (mode_reg == M_LT) || (mode_reg == M_GT) ||
                     (mode_reg == M_EQ) || (mode_reg == M_BANG);

    always_comb
    begin
        unique case (mode_reg)
            M_LT:    held = mk(K_LT, 8'h00, 1'b1);
            M_GT:    held = mk(K_GT, 8'h00, 1'b1);
            M_EQ:    held = mk(K_ASSIGN, 8'h00, 1'b1);
            default: held = mk(K_ERR, C_BANG, 1'b1);
        endcase
    end

    always_comb
    begin
        v0        = 1'b0;
        v1        = 1'b0;
        r0        = ic.res;
        r1        = ic.res;
        mode_next = mode_reg;
        if (eol) begin
            mode_next = M_IDLE;
            if (is_held) begin
                v0 = 1'b1;
                r0 = held;
                v1 = 1'b1;
                r1 = mk(K_EOL, 8'h00, 1'b1);
            end else begin
                v0 = 1'b1;
                r0 = mk(K_EOL, 8'h00, 1'b1);
            end
        end else begin
            unique case (mode_reg)
                M_SKIP: mode_next = M_SKIP;
                M_WORD, M_INT:
                begin
                    if ((mode_reg == M_WORD && is_letter(s_tdata)) ||
                        (mode_reg == M_INT && is_digit(s_tdata))) begin
                        v0 = 1'b1;
                        r0 = mk(mode_reg == M_WORD ? K_WORD : K_INT, s_tdata, 1'b0);
                    end else begin
                        v0        = ic.valid;
                        mode_next = ic.mode;
                    end
                end
                M_LT, M_GT, M_EQ, M_BANG:
                begin
                    v0 = 1'b1;
                    if (s_tdata == C_EQ) begin
                        mode_next = M_IDLE;
                        unique case (mode_reg)
                            M_LT:    r0 = mk(K_LE, 8'h00, 1'b1);
                            M_GT:    r0 = mk(K_GE, 8'h00, 1'b1);
                            M_EQ:    r0 = mk(K_EQ, 8'h00, 1'b1);
                            default: r0 = mk(K_NE, 8'h00, 1'b1);
                        endcase
                    end else if (mode_reg == M_BANG) begin
                        r0        = held;
                        mode_next = M_SKIP;
                    end else begin
                        r0        = held;
                        v1        = ic.valid;
                        mode_next = ic.mode;
                    end
                end
                default:
                begin
                    v0        = ic.valid;
                    mode_next = ic.mode;
                end
            endcase
        end
        if (v1) begin
            r1.last = 1'b1;
        end else begin
            r0.last = 1'b1;
        end
    end

    assign s_tready = (cnt_reg <= 3'd2);
    assign push     = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;
    assign wr1      = wr_reg + 2'd1;
    assign push_n   = push ? ({2'b00, v0} + {2'b00, v1}) : 3'd0;
    assign cnt_next = cnt_reg + push_n - {2'b00, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= M_IDLE;
            wr_reg   <= 2'd0;
            rd_reg   <= 2'd0;
            cnt_reg  <= 3'd0;
        end else begin
            if (push) begin
                mode_reg <= mode_next;
                wr_reg   <= wr_reg + push_n[1:0];
            end
            if (pop) begin
                rd_reg <= rd_reg + 2'd1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && v0) begin
            q_reg[wr_reg] <= r0;
        end
        if (push && v1) begin
            q_reg[wr1] <= r1;
        end
    end

    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tdata  = q_reg[rd_reg].text;
    assign m_tuser  = {q_reg[rd_reg].start, q_reg[rd_reg].kind};
    assign m_tlast  = q_reg[rd_reg].last;

endmodule

[tb/expression_line_tokenizer_core_tb.sv]
// Self-checking testbench for expression_line_tokenizer_core: feeds character beats,
// predicts the token stream in a scoreboard class and checks every output beat.
// Depends on elt_pkg and the expression_line_tokenizer_core RTL.
module expression_line_tokenizer_core_tb;

    import elt_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int CHAR_TARGET  = 690;

    class tokenizer_scoreboard;
        mode_t lex_state;
        res_t  pending_tokens[$];
        res_t  step_tokens[$];
        int    errors;

        function new();
            lex_state = M_IDLE;
            errors    = 0;
        endfunction

        function bit alpha(logic [7:0] c);
            return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
        endfunction

        function bit numeral(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function void emit(kind_t k, logic [7:0] t, logic s);
            res_t r;
            r.kind  = k;
            r.text  = t;
            r.start = s;
            r.last  = 1'b0;
            step_tokens.push_back(r);
        endfunction

        // character seen with nothing held
        function void start_token(logic [7:0] c);
            lex_state = M_IDLE;
            if (c == C_SPACE)
                return;
            if (alpha(c))
            begin
                lex_state = M_WORD;
                emit(K_WORD, c, 1'b1);
            end
            else if (numeral(c))
            begin
                lex_state = M_INT;
                emit(K_INT, c, 1'b1);
            end
            else
            begin
                case (c)
                    C_LPAREN: emit(K_LPAREN, 8'h00, 1'b1);
                    C_RPAREN: emit(K_RPAREN, 8'h00, 1'b1);
                    C_POW:    emit(K_POW, 8'h00, 1'b1);
                    C_PLUS:   emit(K_PLUS, 8'h00, 1'b1);
                    C_MINUS:  emit(K_MINUS, 8'h00, 1'b1);
                    C_STAR:   emit(K_STAR, 8'h00, 1'b1);
                    C_SLASH:  emit(K_SLASH, 8'h00, 1'b1);
                    C_LBRACK: emit(K_LBRACKET, 8'h00, 1'b1);
                    C_RBRACK: emit(K_RBRACKET, 8'h00, 1'b1);
                    C_SEMI:   emit(K_SEMI, 8'h00, 1'b1);
                    C_LT:     lex_state = M_LT;
                    C_GT:     lex_state = M_GT;
                    C_EQ:     lex_state = M_EQ;
                    C_BANG:   lex_state = M_BANG;
                    default:
                    begin
                        lex_state = M_SKIP;
                        emit(K_ERR, c, 1'b1);
                    end
                endcase
            end
        endfunction

        function void flush_held_op();
            case (lex_state)
                M_LT:    emit(K_LT, 8'h00, 1'b1);
                M_GT:    emit(K_GT, 8'h00, 1'b1);
                M_EQ:    emit(K_ASSIGN, 8'h00, 1'b1);
                M_BANG:  emit(K_ERR, C_BANG, 1'b1);
                default: ;
            endcase
        endfunction

        function void note_char(logic [7:0] c);
            kind_t pair;
            res_t  r;
            step_tokens.delete();
            if (c == C_LF || c == C_CR || c == C_NUL)
            begin
                flush_held_op();
                emit(K_EOL, 8'h00, 1'b1);
                lex_state = M_IDLE;
            end
            else
            begin
                case (lex_state)
                    M_SKIP: ;
                    M_WORD:
                        if (alpha(c))
                            emit(K_WORD, c, 1'b0);
                        else
                            start_token(c);
                    M_INT:
                        if (numeral(c))
                            emit(K_INT, c, 1'b0);
                        else
                            start_token(c);
                    M_LT, M_GT, M_EQ, M_BANG:
                        if (c == C_EQ)
                        begin
                            pair = (lex_state == M_LT) ? K_LE :
                                   (lex_state == M_GT) ? K_GE :
                                   (lex_state == M_EQ) ? K_EQ : K_NE;
                            emit(pair, 8'h00, 1'b1);
                            lex_state = M_IDLE;
                        end
                        else if (lex_state == M_BANG)
                        begin
                            // lone bang: error, and the rest of the line is dropped
                            flush_held_op();
                            lex_state = M_SKIP;
                        end
                        else
                        begin
                            flush_held_op();
                            start_token(c);
                        end
                    default: start_token(c);
                endcase
            end
            if (step_tokens.size() > 0)
            begin
                r = step_tokens.pop_back();
                r.last = 1'b1;
                step_tokens.push_back(r);
            end
            foreach (step_tokens[i])
                pending_tokens.push_back(step_tokens[i]);
        endfunction

        function void check_token(res_t got);
            res_t want;
            if (pending_tokens.size() == 0)
            begin
                errors++;
                $display(
                    "%0t: expected none, got kind/text/start/last %0d/%02h/%0b/%0b",
                    $time, got.kind, got.text, got.start, got.last);
                return;
            end
            want = pending_tokens.pop_front();
            if (got !== want)
            begin
                errors++;
                $display(
                    "%0t: kind/text/start/last expected %0d/%02h/%0b/%0b, got %0d/%02h/%0b/%0b",
                    $time, want.kind, want.text, want.start, want.last,
                    got.kind, got.text, got.start, got.last);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [5:0] m_tuser;
    logic       m_tlast;

    tokenizer_scoreboard sb;
    int  chars_sent  = 0;
    int  stall_cycles = 0;
    bit  src_burst   = 1'b0;
    bit  sink_burst  = 1'b0;
    logic [7:0] line_chars[$];

    expression_line_tokenizer_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // beat monitor and watchdog
    always @(posedge clk)
    begin
        res_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_char(s_tdata);
            if (m_tvalid && m_tready)
            begin
                got.kind  = kind_t'(m_tuser[4:0]);
                got.text  = m_tdata;
                got.start = m_tuser[5];
                got.last  = m_tlast;
                sb.check_token(got);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("expression_line_tokenizer_core test failed");
                $finish;
            end
        end
    end

    // result sink with random backpressure
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 63) == 0)
                sink_burst = !sink_burst;
            gap = sink_burst ? 0 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic send_char(input logic [7:0] c);
        int gap;
        if ($urandom_range(0, 63) == 0)
            src_burst = !src_burst;
        gap = src_burst ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge clk); while (!s_tready);
        chars_sent++;
    endtask

    task automatic drain_tokens();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_tokens.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] rand_letter();
        return $urandom_range(0, 1) ? 8'($urandom_range(8'h41, 8'h5A))
                                    : 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    // mostly well-formed expression lines, some noise bytes
    task automatic build_line();
        logic [7:0] single_ops[10];
        logic [7:0] held_ops[4];
        logic [7:0] enders[3];
        int n_tokens;
        int pick;
        single_ops = '{C_LPAREN, C_RPAREN, C_POW, C_PLUS, C_MINUS,
                       C_STAR, C_SLASH, C_LBRACK, C_RBRACK, C_SEMI};
        held_ops   = '{C_LT, C_GT, C_EQ, C_BANG};
        enders     = '{C_LF, C_CR, C_NUL};
        line_chars.delete();
        n_tokens = $urandom_range(1, 8);
        repeat (n_tokens)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                repeat ($urandom_range(1, 4)) line_chars.push_back(rand_letter());
            else if (pick < 45)
                repeat ($urandom_range(1, 4))
                    line_chars.push_back(8'($urandom_range(8'h30, 8'h39)));
            else if (pick < 70)
                line_chars.push_back(single_ops[$urandom_range(0, 9)]);
            else if (pick < 85)
            begin
                line_chars.push_back(held_ops[$urandom_range(0, 3)]);
                if ($urandom_range(0, 1))
                    line_chars.push_back(C_EQ);
            end
            else if (pick < 92)
                repeat ($urandom_range(1, 3)) line_chars.push_back(C_SPACE);
            else
                line_chars.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1))
                line_chars.push_back(C_SPACE);
        end
        line_chars.push_back(enders[$urandom_range(0, 2)]);
    endtask

    initial
    begin
        string first_line;
        logic [7:0] tail_chars[$];
        bit paused_mid;
        sb = new();
        first_line = "a9 ()^+-*/[];<=>=<>==!=<";
        tail_chars = '{C_LF, C_BANG, "x", 8'hFF, C_CR, "!", C_NUL};
        paused_mid = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < first_line.len(); i++)
            send_char(first_line[i]);
        foreach (tail_chars[i])
            send_char(tail_chars[i]);
        drain_tokens();

        while (chars_sent < CHAR_TARGET)
        begin
            build_line();
            foreach (line_chars[i])
                send_char(line_chars[i]);
            if (!paused_mid && chars_sent > CHAR_TARGET / 2)
            begin
                paused_mid = 1'b1;
                drain_tokens();
            end
        end

        drain_tokens();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending_tokens.size() == 0)
            $display("expression_line_tokenizer_core test passed");
        else
            $display("expression_line_tokenizer_core test failed");
        $finish;
    end

endmodule
